>>> sv/iapd_pkg.sv
// shared types and constants of the indexed address postbyte decoder
`timescale 1ns / 1ps

package iapd_pkg;

   typedef logic [7:0]  byte_type;
   typedef logic [15:0] word_type;

   // sub-mode codes in postbyte bits 3:0 when bit 7 is set
   typedef enum logic [3:0] {
      SUB_INC1     = 4'h0,
      SUB_INC2     = 4'h1,
      SUB_DEC1     = 4'h2,
      SUB_DEC2     = 4'h3,
      SUB_ZERO     = 4'h4,
      SUB_ACC_B    = 4'h5,
      SUB_ACC_A    = 4'h6,
      SUB_OFF8     = 4'h8,
      SUB_OFF16    = 4'h9,
      SUB_ACC_D    = 4'hB,
      SUB_PCR8     = 4'hC,
      SUB_PCR16    = 4'hD,
      SUB_EXT_IND  = 4'hF
   } sub_mode_type;

   // register select codes in postbyte bits 6:5
   localparam logic [1:0] SEL_X = 2'd0;
   localparam logic [1:0] SEL_Y = 2'd1;
   localparam logic [1:0] SEL_U = 2'd2;
   localparam logic [1:0] SEL_S = 2'd3;

   // extension byte counts
   localparam logic [1:0] USED_NONE = 2'd0;
   localparam logic [1:0] USED_ONE  = 2'd1;
   localparam logic [1:0] USED_TWO  = 2'd2;

   typedef struct packed {
      byte_type mode_byte;
      byte_type ext_byte_first;
      byte_type ext_byte_second;
      word_type index_x;
      word_type index_y;
      word_type user_stack;
      word_type hw_stack;
      byte_type acc_a;
      byte_type acc_b;
      word_type pc_after_post;
   } req_type;

   // operands and flags handed from decode to the adder stage
   typedef struct packed {
      word_type   op_a;
      word_type   op_b;
      word_type   base;
      word_type   wb_delta;
      logic       is_indirect;
      logic [1:0] bytes_used;
      logic       wb_enable;
      logic [1:0] wb_select;
      logic       illegal_mode;
   } op_type;

   typedef struct packed {
      word_type   eff_address;
      logic       is_indirect;
      logic [1:0] bytes_used;
      logic       wb_enable;
      logic [1:0] wb_select;
      word_type   wb_value;
      logic       illegal_mode;
   } rsp_type;

endpackage

>>> sv/iapd_if.sv
// request and response channel interfaces of the postbyte decoder
`timescale 1ns / 1ps

interface iapd_req_if;
   logic               valid;
   logic               ready;
   iapd_pkg::byte_type mode_byte;
   iapd_pkg::byte_type ext_byte_first;
   iapd_pkg::byte_type ext_byte_second;
   iapd_pkg::word_type index_x;
   iapd_pkg::word_type index_y;
   iapd_pkg::word_type user_stack;
   iapd_pkg::word_type hw_stack;
   iapd_pkg::byte_type acc_a;
   iapd_pkg::byte_type acc_b;
   iapd_pkg::word_type pc_after_post;

   modport source (
      output valid, mode_byte, ext_byte_first, ext_byte_second, index_x, index_y,
             user_stack, hw_stack, acc_a, acc_b, pc_after_post,
      input  ready
   );
   modport sink (
      input  valid, mode_byte, ext_byte_first, ext_byte_second, index_x, index_y,
             user_stack, hw_stack, acc_a, acc_b, pc_after_post,
      output ready
   );
endinterface

interface iapd_rsp_if;
   logic               valid;
   logic               ready;
   iapd_pkg::word_type eff_address;
   logic               is_indirect;
   logic [1:0]         bytes_used;
   logic               wb_enable;
   logic [1:0]         wb_select;
   iapd_pkg::word_type wb_value;
   logic               illegal_mode;

   modport source (
      output valid, eff_address, is_indirect, bytes_used, wb_enable, wb_select,
             wb_value, illegal_mode,
      input  ready
   );
   modport sink (
      input  valid, eff_address, is_indirect, bytes_used, wb_enable, wb_select,
             wb_value, illegal_mode,
      output ready
   );
endinterface

>>> sv/indexed_address_postbyte_decoder_unit.sv
// indexed addressing postbyte decoder: capture, decode and add pipeline
//
//   channel   modport  direction  contents
//   req_if    sink     in         postbyte, extension bytes, registers, pc
//   rsp_if    source   out        address, flags, extension count, write-back
//
// three register stages: input capture, decode to adder operands, add into
// the output register; a transaction taken from req_if passes the capture,
// operand and output registers in that order before it appears on rsp_if,
// and one transaction per cycle is sustained while rsp_if is not stalled
// each stage moves when the stage after it is empty or moving, so a stall on
// rsp_if fills the bubbles first and then holds req_if.ready low
// synchronous reset clears the stage valid bits only
`timescale 1ns / 1ps

module indexed_address_postbyte_decoder_unit (
   input  logic          clock,
   input  logic          reset,
   iapd_req_if.sink      req_if,
   iapd_rsp_if.source    rsp_if
);

   logic adv1, adv2, adv3;
   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;

   iapd_pkg::req_type s1_ff, s1_in;
   iapd_pkg::op_type  s2_ff, s2_in;
   iapd_pkg::rsp_type s3_ff, s3_in;

   assign adv3 = !v3_ff || rsp_if.ready;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign req_if.ready = adv1;

   always_comb begin
      v1_in = adv1 ? req_if.valid : v1_ff;
      v2_in = adv2 ? v1_ff : v2_ff;
      v3_in = adv3 ? v2_ff : v3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // stage 1: capture
   always_comb begin
      s1_in.mode_byte       = req_if.mode_byte;
      s1_in.ext_byte_first  = req_if.ext_byte_first;
      s1_in.ext_byte_second = req_if.ext_byte_second;
      s1_in.index_x         = req_if.index_x;
      s1_in.index_y         = req_if.index_y;
      s1_in.user_stack      = req_if.user_stack;
      s1_in.hw_stack        = req_if.hw_stack;
      s1_in.acc_a           = req_if.acc_a;
      s1_in.acc_b           = req_if.acc_b;
      s1_in.pc_after_post   = req_if.pc_after_post;
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_ff <= s1_in;
      end
   end

   // stage 2: decode into adder operands
   iapd_pkg::word_type base;
   iapd_pkg::word_type n16;
   logic [1:0]         sel;

   always_comb begin
      sel = s1_ff.mode_byte[6:5];
      n16 = {s1_ff.ext_byte_first, s1_ff.ext_byte_second};
      unique case (sel)
         iapd_pkg::SEL_X: base = s1_ff.index_x;
         iapd_pkg::SEL_Y: base = s1_ff.index_y;
         iapd_pkg::SEL_U: base = s1_ff.user_stack;
         iapd_pkg::SEL_S: base = s1_ff.hw_stack;
         default:         base = s1_ff.index_x;
      endcase

      s2_in.op_a         = base;
      s2_in.op_b         = 16'h0000;
      s2_in.base         = base;
      s2_in.wb_delta     = 16'h0000;
      s2_in.is_indirect  = 1'b0;
      s2_in.bytes_used   = iapd_pkg::USED_NONE;
      s2_in.wb_enable    = 1'b0;
      s2_in.wb_select    = sel;
      s2_in.illegal_mode = 1'b0;

      if (!s1_ff.mode_byte[7]) begin
         // 5-bit signed offset
         s2_in.op_b = {{11{s1_ff.mode_byte[4]}}, s1_ff.mode_byte[4:0]};
      end else begin
         s2_in.is_indirect = s1_ff.mode_byte[4];
         unique case (iapd_pkg::sub_mode_type'(s1_ff.mode_byte[3:0]))
            iapd_pkg::SUB_INC1: begin
               if (s1_ff.mode_byte[4]) begin
                  s2_in.illegal_mode = 1'b1;
               end else begin
                  s2_in.wb_enable = 1'b1;
                  s2_in.wb_delta  = 16'h0001;
               end
            end
            iapd_pkg::SUB_INC2: begin
               s2_in.wb_enable = 1'b1;
               s2_in.wb_delta  = 16'h0002;
            end
            iapd_pkg::SUB_DEC1: begin
               if (s1_ff.mode_byte[4]) begin
                  s2_in.illegal_mode = 1'b1;
               end else begin
                  s2_in.wb_enable = 1'b1;
                  s2_in.wb_delta  = 16'hFFFF;
                  s2_in.op_b      = 16'hFFFF;
               end
            end
            iapd_pkg::SUB_DEC2: begin
               s2_in.wb_enable = 1'b1;
               s2_in.wb_delta  = 16'hFFFE;
               s2_in.op_b      = 16'hFFFE;
            end
            iapd_pkg::SUB_ZERO: begin
               s2_in.op_b = 16'h0000;
            end
            iapd_pkg::SUB_ACC_B: begin
               s2_in.op_b = {{8{s1_ff.acc_b[7]}}, s1_ff.acc_b};
            end
            iapd_pkg::SUB_ACC_A: begin
               s2_in.op_b = {{8{s1_ff.acc_a[7]}}, s1_ff.acc_a};
            end
            iapd_pkg::SUB_OFF8: begin
               s2_in.op_b       = {{8{s1_ff.ext_byte_first[7]}}, s1_ff.ext_byte_first};
               s2_in.bytes_used = iapd_pkg::USED_ONE;
            end
            iapd_pkg::SUB_OFF16: begin
               s2_in.op_b       = n16;
               s2_in.bytes_used = iapd_pkg::USED_TWO;
            end
            iapd_pkg::SUB_ACC_D: begin
               s2_in.op_b = {s1_ff.acc_a, s1_ff.acc_b};
            end
            iapd_pkg::SUB_PCR8: begin
               s2_in.op_a       = s1_ff.pc_after_post + 16'd1;
               s2_in.op_b       = {{8{s1_ff.ext_byte_first[7]}}, s1_ff.ext_byte_first};
               s2_in.bytes_used = iapd_pkg::USED_ONE;
            end
            iapd_pkg::SUB_PCR16: begin
               s2_in.op_a       = s1_ff.pc_after_post + 16'd2;
               s2_in.op_b       = n16;
               s2_in.bytes_used = iapd_pkg::USED_TWO;
            end
            iapd_pkg::SUB_EXT_IND: begin
               if (!s1_ff.mode_byte[4]) begin
                  s2_in.illegal_mode = 1'b1;
               end else begin
                  s2_in.op_a       = 16'h0000;
                  s2_in.op_b       = n16;
                  s2_in.bytes_used = iapd_pkg::USED_TWO;
               end
            end
            default: begin
               s2_in.illegal_mode = 1'b1;
            end
         endcase

         // undefined sub-mode or illegal indirect combination falls back to the plain base register
         if (s2_in.illegal_mode) begin
            s2_in.op_a        = base;
            s2_in.op_b        = 16'h0000;
            s2_in.wb_delta    = 16'h0000;
            s2_in.is_indirect = 1'b0;
            s2_in.bytes_used  = iapd_pkg::USED_NONE;
            s2_in.wb_enable   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv2) begin
         s2_ff <= s2_in;
      end
   end

   // stage 3: address and write-back adders into the output register
   always_comb begin
      s3_in.eff_address  = s2_ff.op_a + s2_ff.op_b;
      s3_in.wb_value     = s2_ff.base + s2_ff.wb_delta;
      s3_in.is_indirect  = s2_ff.is_indirect;
      s3_in.bytes_used   = s2_ff.bytes_used;
      s3_in.wb_enable    = s2_ff.wb_enable;
      s3_in.wb_select    = s2_ff.wb_select;
      s3_in.illegal_mode = s2_ff.illegal_mode;
   end

   always_ff @(posedge clock) begin
      if (adv3) begin
         s3_ff <= s3_in;
      end
   end

   assign rsp_if.valid        = v3_ff;
   assign rsp_if.eff_address  = s3_ff.eff_address;
   assign rsp_if.is_indirect  = s3_ff.is_indirect;
   assign rsp_if.bytes_used   = s3_ff.bytes_used;
   assign rsp_if.wb_enable    = s3_ff.wb_enable;
   assign rsp_if.wb_select    = s3_ff.wb_select;
   assign rsp_if.wb_value     = s3_ff.wb_value;
   assign rsp_if.illegal_mode = s3_ff.illegal_mode;

endmodule

>>> sv/iapd_checker.sv
// port-level assertions of the postbyte decoder and their bind
`timescale 1ns / 1ps

module iapd_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input iapd_pkg::word_type rsp_eff_address,
   input logic               rsp_is_indirect,
   input logic [1:0]         rsp_bytes_used,
   input logic               rsp_wb_enable,
   input iapd_pkg::word_type rsp_wb_value,
   input logic               rsp_illegal_mode
);

   // a stalled transaction stays offered
   a_rsp_hold_valid: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid
   ) else $error("response dropped while stalled");

   // a stalled transaction keeps its address and write-back value
   a_rsp_hold_data: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_eff_address) && $stable(rsp_wb_value)
   ) else $error("response payload changed while stalled");

   // illegal mode clears the indirect, write-back and extension-count flags
   a_illegal_clean: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid && rsp_illegal_mode |->
         !rsp_is_indirect && !rsp_wb_enable && (rsp_bytes_used == iapd_pkg::USED_NONE)
   ) else $error("illegal mode with side flags set");

   // modes with extension bytes never write back a register and never report a count of three
   a_ext_no_wb: assert property (
      @(posedge clock) disable iff (reset)
      rsp_valid && (rsp_bytes_used != iapd_pkg::USED_NONE) |->
         !rsp_wb_enable && (rsp_bytes_used != 2'd3)
   ) else $error("extension bytes combined with write-back");

endmodule

bind indexed_address_postbyte_decoder_unit iapd_checker u_iapd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_eff_address  (rsp_if.eff_address),
   .rsp_is_indirect  (rsp_if.is_indirect),
   .rsp_bytes_used   (rsp_if.bytes_used),
   .rsp_wb_enable    (rsp_if.wb_enable),
   .rsp_wb_value     (rsp_if.wb_value),
   .rsp_illegal_mode (rsp_if.illegal_mode)
);
